// ===== hdl/rpa_pkg.sv =====
package rpa_pkg;

  localparam int NUM_PAGES  = 32768;
  localparam int PAGE_BYTES = 4096;
  localparam int COUNT_MAX  = 255;

  localparam int ADDR_W     = 32;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int REFS_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int IDX_W      = $clog2(NUM_PAGES);
  localparam int DEPTH_W    = $clog2(NUM_PAGES + 1);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int CNT_W      = $clog2(COUNT_MAX + 1);

  // Region span in bytes and the width that holds base + span without overflow
  localparam longint REGION_BYTES = longint'(NUM_PAGES) * longint'(PAGE_BYTES);
  localparam int     SPAN_W       = $clog2(REGION_BYTES);
  localparam int     EXT_W        = ((SPAN_W > ADDR_W) ? SPAN_W : ADDR_W) + 1;

  localparam logic [ADDR_W-1:0] REGION_BASE_RST  = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] FIRST_USABLE_RST = 32'h8002_0000;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_ADDREF = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_NO_MEM    = 3'd1,
    STAT_BAD_ADDR  = 3'd2,
    STAT_BAD_COUNT = 3'd3,
    STAT_OVERFLOW  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REGION_BASE  = 1'd0,
    CFG_FIRST_USABLE = 1'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic             addr_ok;
    logic [IDX_W-1:0] idx;
    logic             fresh_ok;
  } chk_t;

endpackage

// ===== hdl/rpa_channels.sv =====
interface rpa_req_if import rpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output kind, output address, input ready);
  modport sink   (input valid, input kind, input address, output ready);
endinterface

interface rpa_rsp_if import rpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   page_address;
  logic                released;
  logic [REFS_W-1:0]   remaining_refs;

  modport source (output valid, output status, output page_address, output released,
                  output remaining_refs, input ready);
  modport sink   (input valid, input status, input page_address, input released,
                  input remaining_refs, output ready);
endinterface

// ===== hdl/rpa_ram.sv =====
module rpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/rpa_check.sv =====
module rpa_check import rpa_pkg::*; (
  input  logic [ADDR_W-1:0]  region_base,
  input  logic [ADDR_W-1:0]  first_usable,
  input  logic [ADDR_W-1:0]  address,
  input  logic [DEPTH_W-1:0] untouched_top,
  output chk_t               chk
);

  logic [EXT_W-1:0] base_ext;
  logic [EXT_W-1:0] fu_ext;
  logic [EXT_W-1:0] addr_ext;
  logic [EXT_W-1:0] region_end;
  logic [EXT_W-1:0] offset;
  logic [EXT_W-1:0] fu_offset;
  logic [EXT_W-1:0] lowest_idx;
  logic             aligned;

  assign base_ext   = EXT_W'(region_base);
  assign fu_ext     = EXT_W'(first_usable);
  assign addr_ext   = EXT_W'(address);
  assign region_end = base_ext + EXT_W'(REGION_BYTES);
  assign offset     = addr_ext - base_ext;
  assign aligned    = (address[PAGE_SHIFT-1:0] == '0);

  // Round the first usable offset up to a whole page
  assign fu_offset  = fu_ext - base_ext + EXT_W'(PAGE_BYTES - 1);
  assign lowest_idx = fu_offset >> PAGE_SHIFT;

  always_comb begin
    chk.addr_ok = aligned && (addr_ext >= fu_ext) && (addr_ext >= base_ext)
                  && (addr_ext < region_end);
    chk.idx     = offset[PAGE_SHIFT +: IDX_W];
    if (fu_ext <= base_ext) begin
      chk.fresh_ok = (untouched_top != '0);
    end else begin
      chk.fresh_ok = (EXT_W'(untouched_top) > lowest_idx);
    end
  end

endmodule

// ===== hdl/refcounted_page_allocator.sv =====
// Reference-counted page allocator. Each request (allocate, free, add reference)
// gives exactly one response. A request passes through a lookup state that reads
// the page's reference count and the free-stack top from single-port-read
// synchronous RAMs and an execute state that updates them and loads the response
// register; the execute state waits while an earlier response is stalled.
// The response register lets the next request start while a response waits.
// Reference counts need no clearing pass after reset: a page below the
// never-used watermark reads as count zero. Configuration writes are taken any
// cycle but must only happen while no request is in flight.
module refcounted_page_allocator import rpa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  rpa_req_if.sink              req,
  rpa_rsp_if.source            rsp
);

  state_t state, state_next;

  logic [ADDR_W-1:0]  region_base;
  logic [ADDR_W-1:0]  first_usable;
  logic [DEPTH_W-1:0] stack_depth, stack_depth_next;
  logic [DEPTH_W-1:0] untouched_top, untouched_top_next;

  logic [KIND_W-1:0]  req_kind;
  logic [ADDR_W-1:0]  req_addr;
  chk_t               chk, chk_q;

  logic               out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [ADDR_W-1:0]  out_page;
  logic               out_released;
  logic [REFS_W-1:0]  out_refs;

  logic               in_ready;
  logic               rd_en;
  logic               exec_fire;

  logic [DEPTH_W-1:0] depth_m1;
  logic [DEPTH_W-1:0] top_m1;
  logic [IDX_W-1:0]   stk_rd_data;
  logic [CNT_W-1:0]   cnt_rd_data;
  logic [CNT_W-1:0]   cnt_cur;

  logic               cnt_we;
  logic [IDX_W-1:0]   cnt_wa;
  logic [CNT_W-1:0]   cnt_wd;
  logic               stk_we;
  logic [IDX_W-1:0]   alloc_idx;

  status_t            res_status;
  logic [ADDR_W-1:0]  res_page;
  logic               res_released;
  logic [REFS_W-1:0]  res_refs;

  assign depth_m1 = stack_depth - 1'b1;
  assign top_m1   = untouched_top - 1'b1;

  rpa_check u_check (
    .region_base   (region_base),
    .first_usable  (first_usable),
    .address       (req_addr),
    .untouched_top (untouched_top),
    .chk           (chk)
  );

  rpa_ram #(.WIDTH(CNT_W), .DEPTH(NUM_PAGES)) u_count_ram (
    .clk     (clk),
    .wr_en   (cnt_we && exec_fire),
    .wr_addr (cnt_wa),
    .wr_data (cnt_wd),
    .rd_en   (rd_en),
    .rd_addr (chk.idx),
    .rd_data (cnt_rd_data)
  );

  rpa_ram #(.WIDTH(IDX_W), .DEPTH(NUM_PAGES)) u_stack_ram (
    .clk     (clk),
    .wr_en   (stk_we && exec_fire),
    .wr_addr (stack_depth[IDX_W-1:0]),
    .wr_data (chk_q.idx),
    .rd_en   (rd_en),
    .rd_addr (depth_m1[IDX_W-1:0]),
    .rd_data (stk_rd_data)
  );

  // Sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (!out_valid || rsp.ready) begin
          state_next = req.valid ? ST_LOOK : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    exec_fire = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_LOOK: begin
        rd_en = 1'b1;
      end
      ST_EXEC: begin
        exec_fire = !out_valid || rsp.ready;
        in_ready  = exec_fire;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign req.ready = in_ready;

  // Pages below the never-used watermark were never handed out: count is zero
  assign cnt_cur = (DEPTH_W'(chk_q.idx) < untouched_top) ? '0 : cnt_rd_data;

  always_comb begin
    res_status         = STAT_OK;
    res_page           = '0;
    res_released       = 1'b0;
    res_refs           = '0;
    cnt_we             = 1'b0;
    cnt_wa             = chk_q.idx;
    cnt_wd             = '0;
    stk_we             = 1'b0;
    alloc_idx          = stk_rd_data;
    stack_depth_next   = stack_depth;
    untouched_top_next = untouched_top;
    case (req_kind) inside
      KIND_ALLOC: begin
        if (stack_depth != '0) begin
          stack_depth_next = depth_m1;
          alloc_idx        = stk_rd_data;
        end else if (chk_q.fresh_ok) begin
          untouched_top_next = top_m1;
          alloc_idx          = top_m1[IDX_W-1:0];
        end
        if ((stack_depth != '0) || chk_q.fresh_ok) begin
          cnt_we   = 1'b1;
          cnt_wa   = alloc_idx;
          cnt_wd   = CNT_W'(1);
          res_page = region_base + (ADDR_W'(alloc_idx) << PAGE_SHIFT);
          res_refs = REFS_W'(1);
        end else begin
          res_status = STAT_NO_MEM;
        end
      end
      KIND_FREE, KIND_ADDREF: begin
        if (!chk_q.addr_ok) begin
          res_status = STAT_BAD_ADDR;
        end else if (cnt_cur == '0) begin
          res_status = STAT_BAD_COUNT;
        end else if (req_kind == KIND_FREE) begin
          cnt_we = 1'b1;
          if (cnt_cur > CNT_W'(1)) begin
            cnt_wd   = cnt_cur - 1'b1;
            res_refs = REFS_W'(cnt_wd);
          end else begin
            cnt_wd       = '0;
            res_released = 1'b1;
            // Drop a push onto a full stack
            if (stack_depth < DEPTH_W'(NUM_PAGES)) begin
              stk_we           = 1'b1;
              stack_depth_next = stack_depth + 1'b1;
            end
          end
        end else begin
          cnt_we = 1'b1;
          if (cnt_cur >= CNT_W'(COUNT_MAX)) begin
            cnt_wd     = CNT_W'(COUNT_MAX);
            res_status = STAT_OVERFLOW;
          end else begin
            cnt_wd = cnt_cur + 1'b1;
          end
          res_refs = REFS_W'(cnt_wd);
        end
      end
      default: begin
        res_status = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      region_base   <= REGION_BASE_RST;
      first_usable  <= FIRST_USABLE_RST;
      stack_depth   <= '0;
      untouched_top <= DEPTH_W'(NUM_PAGES);
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_REGION_BASE:  region_base  <= cfg_data;
          CFG_FIRST_USABLE: first_usable <= cfg_data;
          default: begin
            region_base <= region_base;
          end
        endcase
      end
      if (exec_fire) begin
        stack_depth   <= stack_depth_next;
        untouched_top <= untouched_top_next;
        out_valid     <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && in_ready) begin
      req_kind <= req.kind;
      req_addr <= req.address;
    end
    if (state == ST_LOOK) begin
      chk_q <= chk;
    end
    if (exec_fire) begin
      out_status   <= res_status;
      out_page     <= res_page;
      out_released <= res_released;
      out_refs     <= res_refs;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.page_address   = out_page;
  assign rsp.released       = out_released;
  assign rsp.remaining_refs = out_refs;

endmodule

// ===== hdl/rpa_checker.sv =====
module rpa_checker import rpa_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] rsp_status,
  input logic [ADDR_W-1:0]   rsp_page_address,
  input logic                rsp_released,
  input logic [REFS_W-1:0]   rsp_remaining_refs
);

  // Stalled response holds
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_page_address) && $stable(rsp_remaining_refs))
    else $error("response changed while stalled");

  // A transfer starts the lookup cycle, which takes no new request
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken during lookup");

  // A page returned to the pool leaves no references and no address
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_released |-> rsp_status == STAT_OK
      && rsp_remaining_refs == '0 && rsp_page_address == '0)
    else $error("release response malformed");

  // Out of memory answers all zero
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == STAT_NO_MEM |-> rsp_page_address == '0
      && rsp_remaining_refs == '0 && !rsp_released)
    else $error("out-of-memory response malformed");

  // Saturation reports the maximum count
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == STAT_OVERFLOW |-> rsp_remaining_refs == REFS_W'(COUNT_MAX))
    else $error("overflow response count wrong");

endmodule

bind refcounted_page_allocator rpa_checker u_rpa_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_page_address   (rsp.page_address),
  .rsp_released       (rsp.released),
  .rsp_remaining_refs (rsp.remaining_refs)
);
